### hdl/gsd_pkg.sv
// Shared types, constants and the inverse 6-and-2 code table for the sector decoder.
`timescale 1ns / 1ps

package gsd_pkg;

	localparam int AUX_NIBBLES     = 86;
	localparam int DATA_BYTES      = 256;
	localparam int FIELD_NIBBLES   = AUX_NIBBLES + DATA_BYTES + 1;
	localparam int STATUS_POS      = FIELD_NIBBLES - 1;
	localparam int POS_W           = 9;
	localparam int AUX_ADDR_W      = $clog2(AUX_NIBBLES);
	localparam int QUEUE_DEPTH_DEF = 4;

	localparam logic [7:0] BAD_CODE    = 8'hFF;
	localparam logic       KIND_DATA   = 1'b0;
	localparam logic       KIND_STATUS = 1'b1;

	typedef enum logic [1:0] {
		OP_AUX,
		OP_DATA,
		OP_STATUS
	} op_t;

	// one classified request handed from front to back
	typedef struct packed {
		op_t                   op;
		logic [7:0]            value;
		logic [AUX_ADDR_W-1:0] addr;
		logic [1:0]            shift;
		logic [7:0]            index;
		logic                  err;
	} cmd_t;

	typedef struct packed {
		logic       ok;
		logic [7:0] val;
	} gcr_inv_t;

	localparam logic [7:0] GCR_CODES [64] = '{
		8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
		8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
		8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
		8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
		8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
		8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
		8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
		8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
	};

	function automatic gcr_inv_t gcr_inverse(input logic [7:0] code);
		gcr_inv_t r;
		r.ok  = 1'b0;
		r.val = BAD_CODE;
		for (int i = 0; i < 64; i++) begin
			if (GCR_CODES[i] == code) begin
				r.ok  = 1'b1;
				r.val = 8'(i);
			end
		end
		return r;
	endfunction

endpackage

### hdl/gsd_nib_if.sv
// Nibble request channel: valid/ready with disk nibble and start mark.
`timescale 1ns / 1ps

interface gsd_nib_if;
	logic       valid;
	logic       ready;
	logic [7:0] disk_nibble;
	logic       first;

	modport source (output valid, output disk_nibble, output first, input ready);
	modport sink (input valid, input disk_nibble, input first, output ready);
endinterface

### hdl/gsd_res_if.sv
// Result request channel: valid/ready with decoded byte or field status.
`timescale 1ns / 1ps

interface gsd_res_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	logic [7:0] byte_index;
	logic       checksum_error;
	logic       last;

	modport source (output valid, output kind, output data_byte, output byte_index,
		output checksum_error, output last, input ready);
	modport sink (input valid, input kind, input data_byte, input byte_index,
		input checksum_error, input last, output ready);
endinterface

### hdl/gsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 86
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

### hdl/gsd_front.sv
// Front end: accepts nibbles, decodes them, runs the XOR chain and classifies requests.
`timescale 1ns / 1ps

module gsd_front import gsd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	gsd_nib_if.sink    nibble,
	input  logic       q_full,
	output logic       push,
	output cmd_t       push_cmd
);

	logic [POS_W-1:0] pos_q;
	logic [7:0]       xor_q;

	logic [POS_W-1:0] eff_pos;
	logic [7:0]       base_xor;
	gcr_inv_t         inv;
	logic [7:0]       chained;
	logic             active;
	logic             accept;
	logic [7:0]       bi;
	logic [7:0]       off;
	logic [1:0]       k;

	assign nibble.ready = ~q_full;
	assign accept       = nibble.valid & nibble.ready;

	always_comb begin
		eff_pos  = nibble.first ? '0 : pos_q;
		base_xor = nibble.first ? 8'h00 : xor_q;
		inv      = gcr_inverse(nibble.disk_nibble);
		chained  = inv.val ^ base_xor;
		active   = eff_pos < POS_W'(FIELD_NIBBLES);
		bi       = 8'(eff_pos - POS_W'(AUX_NIBBLES));

		if (bi >= 8'(2 * AUX_NIBBLES)) begin
			k   = 2'd2;
			off = bi - 8'(2 * AUX_NIBBLES);
		end else if (bi >= 8'(AUX_NIBBLES)) begin
			k   = 2'd1;
			off = bi - 8'(AUX_NIBBLES);
		end else begin
			k   = 2'd0;
			off = bi;
		end

		push_cmd.value = chained;
		push_cmd.shift = k;
		push_cmd.index = bi;
		push_cmd.err   = ~inv.ok | (inv.val != base_xor);
		if (eff_pos == POS_W'(STATUS_POS)) begin
			push_cmd.op   = OP_STATUS;
			push_cmd.addr = '0;
		end else if (eff_pos < POS_W'(AUX_NIBBLES)) begin
			push_cmd.op   = OP_AUX;
			push_cmd.addr = AUX_ADDR_W'(POS_W'(AUX_NIBBLES - 1) - eff_pos);
		end else begin
			push_cmd.op   = OP_DATA;
			push_cmd.addr = AUX_ADDR_W'(8'(AUX_NIBBLES - 1) - off);
		end

		push = accept & active;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			xor_q <= '0;
		end else if (push) begin
			pos_q <= eff_pos + 1'b1;
			if (push_cmd.op != OP_STATUS) begin
				xor_q <= chained;
			end
		end
	end

`ifndef SYNTH
	a_pos_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= POS_W'(FIELD_NIBBLES))
		else $error("nibble position past end of field");

	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !nibble.first && pos_q == POS_W'(FIELD_NIBBLES)
		|=> pos_q == POS_W'(FIELD_NIBBLES))
		else $error("nibble position left saturation without start mark");
`endif

endmodule

### hdl/gsd_queue.sv
// Short request queue between front and back.
`timescale 1ns / 1ps

module gsd_queue import gsd_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic not_empty,
	output cmd_t pop_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full      = count_q == CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign pop_cmd   = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTH
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!not_empty |-> !pop)
		else $error("pop from empty queue");
`endif

endmodule

### hdl/gsd_back.sv
// Back end: aux RAM access, byte assembly and the result output register.
`timescale 1ns / 1ps

module gsd_back import gsd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_valid,
	input  cmd_t      q_cmd,
	output logic      pop,
	gsd_res_if.source result
);

	cmd_t       cmd_s1;
	logic       valid_s1;
	logic [7:0] aux_rdata;
	logic [7:0] aux_shifted;
	logic       has_res;
	logic       out_free;
	logic       adv_s1;
	logic       take_s1;
	logic       out_valid_q;

	gsd_ram #(
		.WIDTH (8),
		.DEPTH (AUX_NIBBLES)
	) u_aux_ram (
		.clk   (clk),
		.we    (pop && q_cmd.op == OP_AUX),
		.waddr (q_cmd.addr),
		.wdata (q_cmd.value),
		.re    (pop && q_cmd.op == OP_DATA),
		.raddr (q_cmd.addr),
		.rdata (aux_rdata)
	);

	always_comb begin
		has_res     = valid_s1 && cmd_s1.op != OP_AUX;
		out_free    = ~out_valid_q | result.ready;
		adv_s1      = valid_s1 && (!has_res || out_free);
		take_s1     = ~valid_s1 | adv_s1;
		pop         = q_valid & take_s1;
		aux_shifted = aux_rdata >> {cmd_s1.shift, 1'b0};
	end

	assign result.valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			if (adv_s1 && has_res) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_s1 <= q_cmd;
		end
		if (adv_s1 && has_res) begin
			case (cmd_s1.op)
				OP_STATUS: begin
					result.kind           <= KIND_STATUS;
					result.data_byte      <= 8'h00;
					result.byte_index     <= 8'h00;
					result.checksum_error <= cmd_s1.err;
					result.last           <= 1'b1;
				end
				default: begin
					result.kind           <= KIND_DATA;
					result.data_byte      <= {cmd_s1.value[5:0], aux_shifted[0], aux_shifted[1]};
					result.byte_index     <= cmd_s1.index;
					result.checksum_error <= 1'b0;
					result.last           <= 1'b0;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_status_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind == KIND_STATUS
		|-> result.last && result.data_byte == 8'h00 && result.byte_index == 8'h00)
		else $error("status result carries data");

	a_data_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.kind == KIND_DATA |-> !result.last && !result.checksum_error)
		else $error("data result flagged as status");
`endif

endmodule

### hdl/gcr_6and2_sector_decoder.sv
// Top level of the 6-and-2 GCR data field decoder.
//
//   channel   dir   handshake      payload
//   nibble    in    valid/ready    disk_nibble[7:0], first
//   result    out   valid/ready    kind, data_byte[7:0], byte_index[7:0], checksum_error, last
//
// One nibble per cycle while the queue is not full; each result is registered at the output.
// The aux RAM read is registered, so each data byte passes through the RAM stage.
// Reset clears position and XOR chain; the aux RAM is not cleared, nibbles 0..85 fill it.
// nibble.ready drops only when the request queue (QUEUE_DEPTH entries) is full.
`timescale 1ns / 1ps

module gcr_6and2_sector_decoder import gsd_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	gsd_nib_if.sink   nibble,
	gsd_res_if.source result
);

	logic push;
	cmd_t push_cmd;
	logic q_full;
	logic pop;
	logic q_valid;
	cmd_t q_cmd;

	gsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.nibble   (nibble),
		.q_full   (q_full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	gsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.pop_cmd   (q_cmd)
	);

	gsd_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.pop     (pop),
		.result  (result)
	);

endmodule
